/* rtl/core/osps_pkg.sv */
// Shared types and operation codes for the ordered set block.
package osps_pkg;

	typedef logic [1:0] func_t;

	localparam func_t FUNC_INSERT = 2'd0;
	localparam func_t FUNC_LOOKUP = 2'd1;
	localparam func_t FUNC_SUCC   = 2'd2;
	localparam func_t FUNC_PRED   = 2'd3;

endpackage

/* rtl/core/osps_req_if.sv */
// Request and response channel interfaces of the ordered set block.
interface osps_req_if #(
	parameter int KEY_BITS = 10
);
	logic                  valid;
	logic                  ready;
	osps_pkg::func_t       func;
	logic [KEY_BITS-1:0]   key;

	modport source (output valid, output func, output key, input ready);
	modport sink   (input valid, input func, input key, output ready);
endinterface

interface osps_rsp_if #(
	parameter int KEY_BITS = 10
);
	logic                       valid;
	logic                       ready;
	logic                       is_member;
	logic signed [KEY_BITS+1:0] result_key;
	logic                       none_found;

	modport source (output valid, output is_member, output result_key, output none_found,
		input ready);
	modport sink   (input valid, input is_member, input result_key, input none_found,
		output ready);
endinterface

/* rtl/core/ordered_set_pred_succ_top.sv */
// A lookup reads the prefix memory once; successor and predecessor binary-search the trie levels,
// then read the link and neighbour memories. Insert of a new key runs a neighbour search and
// then a per-level read-modify-write of the trie; a duplicate insert ends after the lookup.
// One item is in work at a time; the memories are synchronous, with registered read data.
// A waiting result is held in the output register while the next item is taken; a finished
// result that cannot yet enter the output register holds off new items. After reset the
// block sweeps the prefix and link memories and accepts no item until the sweep ends.
module ordered_set_pred_succ_top #(
	parameter int KEY_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	osps_req_if.sink    req,
	osps_rsp_if.source  rsp
);

	localparam int PA_W   = KEY_BITS + 1;
	localparam int PRES_N = (2 << KEY_BITS) - 1;
	localparam int LINK_N = (1 << KEY_BITS) - 1;
	localparam int LEAF_N = 1 << KEY_BITS;
	localparam int LVW    = $clog2(KEY_BITS + 2);
	localparam int LK_W   = KEY_BITS + 1;

	typedef enum logic [13:0] {
		ST_CLR      = 14'b00000000000001,
		ST_IDLE     = 14'b00000000000010,
		ST_MEMB     = 14'b00000000000100,
		ST_MEMB_CHK = 14'b00000000001000,
		ST_SRCH     = 14'b00000000010000,
		ST_SRCH_CHK = 14'b00000000100000,
		ST_NB_LEAF  = 14'b00000001000000,
		ST_LINK_CHK = 14'b00000010000000,
		ST_NB_FILL  = 14'b00000100000000,
		ST_RES      = 14'b00001000000000,
		ST_BEL_UPD  = 14'b00010000000000,
		ST_ABV_UPD  = 14'b00100000000000,
		ST_LVL      = 14'b01000000000000,
		ST_LVL_CHK  = 14'b10000000000000
	} state_t;

	// Memories.
	logic              pres_mem [PRES_N];
	logic [LK_W-1:0]   link_mem [LINK_N];
	logic [2*LK_W-1:0] nb_mem   [LEAF_N];

	state_t state_q;
	logic [PA_W-1:0]      clr_q;
	osps_pkg::func_t      func_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [LVW-1:0]       lo_q, hi_q, lvl_q;
	logic [LK_W-1:0]      below_q, above_q;
	logic                 fill_above_q;
	logic                 done_q;
	logic                 res_member_q, res_none_q;
	logic signed [KEY_BITS+1:0] res_key_q;

	logic                 out_valid_q, out_member_q, out_none_q;
	logic signed [KEY_BITS+1:0] out_key_q;

	logic                 pres_rd_q;
	logic [LK_W-1:0]      link_rd_q;
	logic [2*LK_W-1:0]    nb_rd_q;

	logic                 pres_we, link_we, nb_we;
	logic [PA_W-1:0]      pres_waddr, pres_raddr;
	logic                 pres_wdata;
	logic [KEY_BITS-1:0]  link_waddr, link_raddr, nb_waddr, nb_raddr;
	logic [LK_W-1:0]      link_wdata;
	logic [2*LK_W-1:0]    nb_wdata;

	logic [LVW:0]         lohi_sum;
	logic [LVW-1:0]       mid;
	logic                 in_acc, out_free, key_bit;
	logic [KEY_BITS-1:0]  sib_key;

	function automatic logic [PA_W-1:0] node_at(logic [LVW-1:0] lv, logic [KEY_BITS-1:0] k);
		logic [KEY_BITS-1:0] pfx;
		pfx = k >> (KEY_BITS - int'(lv));
		return ((PA_W'(1) << lv) - PA_W'(1)) + PA_W'(pfx);
	endfunction

	assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = lohi_sum[LVW:1];
	assign in_acc   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign key_bit  = key_q[KEY_BITS - int'(lvl_q)];
	assign sib_key  = key_q ^ (KEY_BITS'(1) << (KEY_BITS - int'(lvl_q)));

	assign req.ready      = (state_q == ST_IDLE) && !done_q;
	assign rsp.valid      = out_valid_q;
	assign rsp.is_member  = out_member_q;
	assign rsp.result_key = out_key_q;
	assign rsp.none_found = out_none_q;

	// Read addresses and write ports.
	always_comb begin
		pres_raddr = node_at(LVW'(KEY_BITS), key_q);
		link_raddr = KEY_BITS'(node_at(lo_q, key_q));
		nb_raddr   = key_q;
		pres_we    = 1'b0;
		pres_waddr = clr_q;
		pres_wdata = 1'b1;
		link_we    = 1'b0;
		link_waddr = KEY_BITS'(node_at(lvl_q - LVW'(1), key_q));
		link_wdata = {1'b1, key_q};
		nb_we      = 1'b0;
		nb_waddr   = key_q;
		nb_wdata   = {below_q, above_q};
		unique case (state_q)
			ST_CLR: begin
				pres_we    = 1'b1;
				pres_wdata = (clr_q == '0);
				link_we    = (clr_q < PA_W'(LINK_N));
				link_waddr = clr_q[KEY_BITS-1:0];
				link_wdata = '0;
			end
			ST_SRCH: begin
				pres_raddr = node_at(mid, key_q);
			end
			ST_LINK_CHK: begin
				nb_raddr = link_rd_q[KEY_BITS-1:0];
			end
			ST_RES: begin
				nb_we    = (func_q == osps_pkg::FUNC_INSERT);
				nb_raddr = below_q[LK_W-1] ? below_q[KEY_BITS-1:0] : above_q[KEY_BITS-1:0];
			end
			ST_BEL_UPD: begin
				nb_we    = 1'b1;
				nb_waddr = below_q[KEY_BITS-1:0];
				nb_wdata = {nb_rd_q[2*LK_W-1:LK_W], 1'b1, key_q};
				nb_raddr = above_q[KEY_BITS-1:0];
			end
			ST_ABV_UPD: begin
				nb_we    = 1'b1;
				nb_waddr = above_q[KEY_BITS-1:0];
				nb_wdata = {1'b1, key_q, nb_rd_q[LK_W-1:0]};
			end
			ST_LVL: begin
				pres_we    = 1'b1;
				pres_waddr = node_at(lvl_q, key_q);
				pres_raddr = node_at(lvl_q, sib_key);
				link_raddr = KEY_BITS'(node_at(lvl_q - LVW'(1), key_q));
			end
			ST_LVL_CHK: begin
				if (!pres_rd_q) begin
					if (key_bit)
						link_we = !link_rd_q[LK_W-1] || (key_q < link_rd_q[KEY_BITS-1:0]);
					else
						link_we = !link_rd_q[LK_W-1] || (key_q > link_rd_q[KEY_BITS-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pres_we)
			pres_mem[pres_waddr] <= pres_wdata;
		if (link_we)
			link_mem[link_waddr] <= link_wdata;
		if (nb_we)
			nb_mem[nb_waddr] <= nb_wdata;
	end

	always_ff @(posedge clk) begin
		pres_rd_q <= pres_mem[pres_raddr];
		link_rd_q <= link_mem[link_raddr];
		nb_rd_q   <= nb_mem[nb_raddr];
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_q && out_free) begin
				out_valid_q <= 1'b1;
				done_q      <= 1'b0;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + PA_W'(1);
					if (clr_q == PA_W'(PRES_N - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (req.func == osps_pkg::FUNC_INSERT ||
						    req.func == osps_pkg::FUNC_LOOKUP)
							state_q <= ST_MEMB;
						else
							state_q <= ST_SRCH;
					end
				end
				ST_MEMB: state_q <= ST_MEMB_CHK;
				ST_MEMB_CHK: begin
					if (func_q == osps_pkg::FUNC_LOOKUP || pres_rd_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (lo_q + LVW'(1) == hi_q)
						state_q <= (lo_q == LVW'(KEY_BITS)) ? ST_NB_LEAF : ST_LINK_CHK;
					else
						state_q <= ST_SRCH_CHK;
				end
				ST_SRCH_CHK: state_q <= ST_SRCH;
				ST_NB_LEAF:  state_q <= ST_RES;
				ST_LINK_CHK: state_q <= link_rd_q[LK_W-1] ? ST_NB_FILL : ST_RES;
				ST_NB_FILL:  state_q <= ST_RES;
				ST_RES: begin
					if (func_q != osps_pkg::FUNC_INSERT) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (below_q[LK_W-1]) begin
						state_q <= ST_BEL_UPD;
					end else if (above_q[LK_W-1]) begin
						state_q <= ST_ABV_UPD;
					end else begin
						state_q <= ST_LVL;
					end
				end
				ST_BEL_UPD: state_q <= above_q[LK_W-1] ? ST_ABV_UPD : ST_LVL;
				ST_ABV_UPD: state_q <= ST_LVL;
				ST_LVL:     state_q <= ST_LVL_CHK;
				ST_LVL_CHK: begin
					if (lvl_q == LVW'(KEY_BITS)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LVL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (done_q && out_free) begin
			out_member_q <= res_member_q;
			out_key_q    <= res_key_q;
			out_none_q   <= res_none_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					func_q       <= req.func;
					key_q        <= req.key;
					lo_q         <= '0;
					hi_q         <= LVW'(KEY_BITS + 1);
					lvl_q        <= LVW'(1);
					res_member_q <= 1'b0;
					res_key_q    <= '0;
					res_none_q   <= 1'b0;
				end
			end
			ST_MEMB_CHK: begin
				if (func_q == osps_pkg::FUNC_LOOKUP)
					res_member_q <= pres_rd_q;
			end
			ST_SRCH_CHK: begin
				if (pres_rd_q)
					lo_q <= mid;
				else
					hi_q <= mid;
			end
			ST_NB_LEAF: begin
				below_q <= nb_rd_q[2*LK_W-1:LK_W];
				above_q <= nb_rd_q[LK_W-1:0];
			end
			ST_LINK_CHK: begin
				if (!link_rd_q[LK_W-1]) begin
					below_q <= '0;
					above_q <= '0;
				end else if (link_rd_q[KEY_BITS-1:0] < key_q) begin
					below_q      <= link_rd_q;
					fill_above_q <= 1'b1;
				end else begin
					above_q      <= link_rd_q;
					fill_above_q <= 1'b0;
				end
			end
			ST_NB_FILL: begin
				if (fill_above_q)
					above_q <= nb_rd_q[LK_W-1:0];
				else
					below_q <= nb_rd_q[2*LK_W-1:LK_W];
			end
			ST_RES: begin
				if (func_q == osps_pkg::FUNC_SUCC) begin
					res_none_q <= !above_q[LK_W-1];
					res_key_q  <= above_q[LK_W-1] ?
						(KEY_BITS+2)'({2'b00, above_q[KEY_BITS-1:0]}) :
						(KEY_BITS+2)'(1) <<< KEY_BITS;
				end else if (func_q == osps_pkg::FUNC_PRED) begin
					res_none_q <= !below_q[LK_W-1];
					res_key_q  <= below_q[LK_W-1] ?
						(KEY_BITS+2)'({2'b00, below_q[KEY_BITS-1:0]}) :
						-((KEY_BITS+2)'(1) <<< KEY_BITS);
				end
			end
			ST_LVL_CHK: begin
				lvl_q <= lvl_q + LVW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule
